>>> hw/rtl/slri_pkg.sv
package slri_pkg;

    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int DEPTH_DEF   = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic              ins_en;
        logic              rem_en;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              after;
        logic              ge;
        logic              eq;
    } t_cell_out;

endpackage

>>> hw/rtl/slri_cell.sv
module slri_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slri_pkg::t_cell_ctl   i_ctl,
    input  slri_pkg::t_cell_out   i_left,
    input  slri_pkg::t_cell_out   i_right,
    output slri_pkg::t_cell_out   o_cell
);

    logic [slri_pkg::DATA_W-1:0] r_data;
    logic [slri_pkg::DATA_W-1:0] n_data;
    logic                        r_valid;
    logic                        n_valid;
    logic                        w_after;
    logic                        w_ge;
    logic                        w_eq;

    // The new value belongs at or before this cell when the cell is empty
    // or holds a strictly larger value.
    assign w_after = !r_valid || ($signed(i_ctl.value) < $signed(r_data));
    assign w_ge    = r_valid && !($signed(r_data) < $signed(i_ctl.value));
    assign w_eq    = r_valid && (r_data == i_ctl.value);

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.ins_en) begin
            if (i_left.after) begin
                n_data = i_left.data;
            end else if (w_after) begin
                n_data = i_ctl.value;
            end
            n_valid = r_valid || i_left.valid;
        end else if (i_ctl.rem_en && w_ge) begin
            n_data  = i_right.data;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_cell = '{data: r_data, valid: r_valid, after: w_after, ge: w_ge, eq: w_eq};

endmodule

>>> hw/rtl/sorted_list_insert_remove.sv
// Sorted list of signed 32-bit values held in a row of cells, smallest first.
// Input channel (s_axis): tuser carries the command (insert, remove, read),
// tdata carries the value and the read index. Output channel (m_axis): one
// result transaction per command with status, count after the command and
// the value read.
// Every cell compares the value with its entry and takes its own, its left or
// its right neighbor's entry in parallel, so a command is accepted in every
// cycle while the output register is free, and its result appears in the
// output register in the cycle after acceptance.
// Insert places the value after any equal entries; a full list refuses it.
// Remove takes out the first equal entry; an absent value is reported.
// Read returns the entry at the index, or zero with an error status when the
// index is not below the count.
// After reset the list is empty and no result is pending.
// When the receiver stalls, the result is held and a new command is accepted
// only in a cycle in which the output register is empty or being emptied.
module sorted_list_insert_remove #(
    parameter int DEPTH = slri_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [31:0] value, [35:32] index, [39:36] zero
    input  logic [slri_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [1:0] status, [6:2] count, [38:7] read_value, [39] zero
    output logic [slri_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > slri_pkg::INDEX_W) ? CW : slri_pkg::INDEX_W;
    localparam int NREAD = (DEPTH < 16) ? DEPTH : 16;

    logic                                w_s_acc;
    logic [slri_pkg::DATA_W-1:0]         w_value;
    logic [slri_pkg::INDEX_W-1:0]        w_index;
    slri_pkg::t_cmd                      w_cmd;
    logic                                w_full;
    logic                                w_found;
    slri_pkg::t_cell_ctl                 w_ctl;
    slri_pkg::t_cell_out                 w_cells [DEPTH];
    slri_pkg::t_cell_out                 w_left  [DEPTH];
    slri_pkg::t_cell_out                 w_right [DEPTH];
    logic [DEPTH-1:0]                    w_valid_vec;
    logic [DEPTH-1:0]                    w_eq_vec;
    logic [slri_pkg::DATA_W-1:0]         w_rd_mux;

    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic                                r_m_valid;
    logic                                n_m_valid;
    slri_pkg::t_status                   r_status;
    slri_pkg::t_status                   n_status;
    logic [slri_pkg::COUNT_OUT_W-1:0]    r_count_out;
    logic [slri_pkg::COUNT_OUT_W-1:0]    n_count_out;
    logic [slri_pkg::DATA_W-1:0]         r_rd;
    logic [slri_pkg::DATA_W-1:0]         n_rd;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_value         = i_s_axis_tdata[slri_pkg::DATA_W-1:0];
    assign w_index         = i_s_axis_tdata[slri_pkg::DATA_W +: slri_pkg::INDEX_W];
    assign w_cmd           = slri_pkg::t_cmd'(i_s_axis_tuser);
    assign w_full          = (r_count == CW'(DEPTH));
    assign w_found         = |w_eq_vec;

    assign w_ctl.value  = w_value;
    assign w_ctl.ins_en = w_s_acc && (w_cmd == slri_pkg::CMD_INSERT) && !w_full;
    assign w_ctl.rem_en = w_s_acc && (w_cmd == slri_pkg::CMD_REMOVE) && w_found;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_lb
                assign w_left[g] = '{data: '0, valid: 1'b1, after: 1'b0, ge: 1'b0, eq: 1'b0};
            end else begin : g_ln
                assign w_left[g] = w_cells[g-1];
            end
            if (g == DEPTH - 1) begin : g_rb
                assign w_right[g] = '{data: '0, valid: 1'b0, after: 1'b1, ge: 1'b0,
                                      eq: 1'b0};
            end else begin : g_rn
                assign w_right[g] = w_cells[g+1];
            end

            slri_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_cell  (w_cells[g])
            );

            assign w_valid_vec[g] = w_cells[g].valid;
            assign w_eq_vec[g]    = w_cells[g].eq;
        end
    endgenerate

    always_comb begin
        w_rd_mux = '0;
        for (int i = 0; i < NREAD; i++) begin
            if (w_index == slri_pkg::INDEX_W'(i)) begin
                w_rd_mux = w_cells[i].data;
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_m_valid   = r_m_valid;
        n_status    = r_status;
        n_count_out = r_count_out;
        n_rd        = r_rd;
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (w_s_acc) begin
            n_m_valid = 1'b1;
            n_status  = slri_pkg::ST_DONE;
            n_rd      = '0;
            case (w_cmd)
                slri_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        n_status = slri_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                slri_pkg::CMD_REMOVE: begin
                    if (w_found) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_status = slri_pkg::ST_NOT_FOUND;
                    end
                end
                slri_pkg::CMD_READ: begin
                    if (CMPW'(w_index) >= CMPW'(r_count)) begin
                        n_status = slri_pkg::ST_BAD_INDEX;
                    end else begin
                        n_rd = w_rd_mux;
                    end
                end
                default: begin
                end
            endcase
            n_count_out = slri_pkg::COUNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_count_out <= n_count_out;
        r_rd        <= n_rd;
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_rd, r_count_out, r_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(DEPTH))
        else $error("entry count exceeds list depth");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("occupied cells disagree with entry count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem_en |=> (r_count == $past(r_count) - CW'(1)))
        else $error("successful remove did not shrink the list");

    a_reported_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_count_out == slri_pkg::COUNT_OUT_W'(r_count)))
        else $error("reported count differs from held count");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import slri_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_status                status;
        logic [COUNT_OUT_W-1:0] count;
        logic [DATA_W-1:0]      read_value;
    } t_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic [1:0]           i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    logic signed [DATA_W-1:0] list_model [LIST_DEPTH];
    int      list_len    = 0;
    t_result pending_results [$];
    int      gap_pct     = 0;
    int      stall_pct   = 0;
    int      errors      = 0;
    int      checked     = 0;
    int      n_full      = 0;
    int      n_missing   = 0;
    int      n_bad_index = 0;

    sorted_list_insert_remove u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void apply_command(input logic [1:0] cmd,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [INDEX_W-1:0] idx);
        t_result res;
        int      pos;
        res.status     = ST_DONE;
        res.read_value = '0;
        if (cmd == CMD_INSERT) begin
            if (list_len >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < list_len && !(val < list_model[pos])) pos++;
                for (int i = list_len; i > pos; i--) list_model[i] = list_model[i-1];
                list_model[pos] = val;
                list_len++;
            end
        end else if (cmd == CMD_REMOVE) begin
            pos = 0;
            while (pos < list_len && list_model[pos] != val) pos++;
            if (pos >= list_len) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
                list_len--;
            end
        end else if (cmd == CMD_READ) begin
            if (int'(idx) >= list_len) begin
                res.status = ST_BAD_INDEX;
            end else begin
                res.read_value = list_model[idx];
            end
        end
        res.count = COUNT_OUT_W'(list_len);
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.status     = t_status'(o_m_axis_tdata[1:0]);
                got.count      = o_m_axis_tdata[6:2];
                got.read_value = o_m_axis_tdata[38:7];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected transaction", o_m_axis_tdata[31:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_NOT_FOUND) n_missing++;
                    if (want.status == ST_BAD_INDEX) n_bad_index++;
                    if (got.status != want.status) begin
                        report_mismatch("status", got.status, want.status);
                    end
                    if (got.count != want.count) begin
                        report_mismatch("count", got.count, want.count);
                    end
                    if (got.read_value != want.read_value) begin
                        report_mismatch("read_value", got.read_value, want.read_value);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_command(i_s_axis_tuser, i_s_axis_tdata[31:0], i_s_axis_tdata[35:32]);
            end
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [DATA_W-1:0] val,
                            input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {4'b0000, idx, val};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_edge_cases();
        gap_pct   = 0;
        stall_pct = 0;
        send_cmd(CMD_READ, '0, 4'd0);
        send_cmd(CMD_REMOVE, 32'd5, 4'd0);
        send_cmd(CMD_UNUSED, '1, '1);
        send_cmd(CMD_INSERT, 32'h7fff_ffff, '1);
        send_cmd(CMD_INSERT, 32'h8000_0000, 4'd0);
        send_cmd(CMD_INSERT, '0, 4'd0);
        send_cmd(CMD_INSERT, '0, 4'd0);
        send_cmd(CMD_INSERT, '1, 4'd0);
        send_cmd(CMD_READ, '1, 4'd0);
        send_cmd(CMD_READ, '0, 4'd4);
        send_cmd(CMD_REMOVE, '0, 4'd0);
        send_cmd(CMD_READ, '0, 4'd2);
        send_cmd(CMD_READ, '0, 4'd4);
        send_cmd(CMD_READ, '0, 4'd15);
        send_cmd(CMD_UNUSED, 32'h1234_5678, 4'd3);
        wait_for_results();
    endtask

    task automatic test_fill_to_full();
        int                room;
        logic [DATA_W-1:0] low_entry;
        gap_pct   = 35;
        stall_pct = 35;
        room = LIST_DEPTH - list_len;
        repeat (room) send_cmd(CMD_INSERT, $urandom, INDEX_W'($urandom_range(15)));
        send_cmd(CMD_INSERT, $urandom, 4'd0);
        send_cmd(CMD_READ, $urandom, 4'd15);
        send_cmd(CMD_READ, '0, 4'd0);
        wait_for_results();
        low_entry = list_model[0];
        send_cmd(CMD_REMOVE, low_entry, 4'd0);
        send_cmd(CMD_REMOVE, $urandom, 4'd0);
        send_cmd(CMD_INSERT, 32'h8000_0000, 4'd0);
        send_cmd(CMD_INSERT, 32'h7fff_ffff, 4'd0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int items);
        logic [DATA_W-1:0] pool [8];
        logic [1:0]        cmd;
        logic [DATA_W-1:0] val;
        int                insert_pct;
        int                roll;
        gap_pct    = gap;
        stall_pct  = stall;
        pool[0]    = 32'h8000_0000;
        pool[1]    = 32'h7fff_ffff;
        pool[2]    = '0;
        pool[3]    = '1;
        insert_pct = 50;
        for (int i = 4; i < 8; i++) pool[i] = $urandom;
        for (int n = 0; n < items; n++) begin
            if (n % 60 == 0) insert_pct = $urandom_range(1) ? 75 : 25;
            roll = $urandom_range(99);
            if (roll < 3) begin
                cmd = CMD_UNUSED;
            end else if (roll < 25) begin
                cmd = CMD_READ;
            end else if ($urandom_range(99) < insert_pct) begin
                cmd = CMD_INSERT;
            end else begin
                cmd = CMD_REMOVE;
            end
            val = ($urandom_range(99) < 60) ? pool[3'($urandom_range(7))] : $urandom;
            send_cmd(cmd, val, INDEX_W'($urandom_range(15)));
            if (n == items / 2) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_fill_to_full();
        test_random_traffic(0, 0, 200);
        test_random_traffic(88, 0, 200);
        test_random_traffic(0, 88, 200);
        test_random_traffic(35, 35, 200);
        repeat (10) @(posedge i_clk);
        $display("Checked %0d result transactions over directed and random traffic,", checked);
        $display("including %0d full, %0d not found and %0d bad index outcomes.",
                 n_full, n_missing, n_bad_index);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
